// ===== src/ard_pkg.sv =====
// Shared types, codes and the signature byte table for the archive record deframer.
// No dependencies; every other file of the block refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package ard_pkg;

	localparam int SIG_LEN = 7;

	localparam logic [7:0] TAG_NAME = 8'hFF;
	localparam logic [7:0] TAG_END  = 8'hFE;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_TAG  = 3'd1,
		PH_NAME = 3'd2,
		PH_DATA = 3'd3,
		PH_END  = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		CL_SIG_OK    = 4'd0,
		CL_SIG_ERR   = 4'd1,
		CL_NAME_MARK = 4'd2,
		CL_NAME_BYTE = 4'd3,
		CL_NAME_END  = 4'd4,
		CL_LENGTH    = 4'd5,
		CL_DATA      = 4'd6,
		CL_END       = 4'd7,
		CL_IGNORED   = 4'd8
	} byte_class_t;

	typedef struct packed {
		logic [7:0] archive_byte;
		logic       restart;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] byte_class;
		logic [7:0] byte_value;
		logic [7:0] chunk_remaining;
	} out_beat_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] sig_idx;
		logic [7:0] skip;
	} parse_state_t;

	// expected archive signature, one byte per position
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h52;
			3'd1: b = 8'h69;
			3'd2: b = 8'h50;
			3'd3: b = 8'h6F;
			3'd4: b = 8'h72;
			3'd5: b = 8'h46;
			3'd6: b = 8'h53;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/ard_classify.sv =====
// Byte classifier: next parser state and result beat for one archive byte.
// Purely combinational; uses ard_pkg types and the signature table.
`timescale 1ns / 1ps
`default_nettype none

module ard_classify (
	input  var ard_pkg::parse_state_t state_q,
	input  var ard_pkg::in_beat_t     beat,
	output ard_pkg::parse_state_t     state_d,
	output ard_pkg::out_beat_t        result
);

	ard_pkg::parse_state_t cur;
	ard_pkg::byte_class_t  cls;
	logic [7:0]            rem;
	logic [7:0]            b;
	logic [7:0]            skip_dec;

	assign b = beat.archive_byte;

	always_comb begin
		// restart takes this byte as the first signature byte
		if (beat.restart) begin
			cur.phase   = ard_pkg::PH_SIG;
			cur.sig_idx = '0;
			cur.skip    = '0;
		end else begin
			cur = state_q;
		end

		state_d  = cur;
		cls      = ard_pkg::CL_IGNORED;
		rem      = '0;
		skip_dec = (cur.skip != '0) ? cur.skip - 8'd1 : cur.skip;

		case (cur.phase)
			ard_pkg::PH_SIG: begin
				if (b == ard_pkg::sig_byte(cur.sig_idx)) begin
					cls = ard_pkg::CL_SIG_OK;
					if (cur.sig_idx == 3'(ard_pkg::SIG_LEN - 1)) begin
						state_d.sig_idx = '0;
						state_d.phase   = ard_pkg::PH_TAG;
					end else begin
						state_d.sig_idx = cur.sig_idx + 3'd1;
					end
				end else begin
					cls           = ard_pkg::CL_SIG_ERR;
					state_d.phase = ard_pkg::PH_ERR;
				end
			end
			ard_pkg::PH_TAG: begin
				if (b == ard_pkg::TAG_NAME) begin
					cls           = ard_pkg::CL_NAME_MARK;
					state_d.phase = ard_pkg::PH_NAME;
				end else if (b == ard_pkg::TAG_END) begin
					cls           = ard_pkg::CL_END;
					state_d.phase = ard_pkg::PH_END;
				end else begin
					cls          = ard_pkg::CL_LENGTH;
					state_d.skip = b;
					rem          = b;
					// empty chunk stays in the tag phase
					if (b != '0) begin
						state_d.phase = ard_pkg::PH_DATA;
					end
				end
			end
			ard_pkg::PH_NAME: begin
				if (b == '0) begin
					cls           = ard_pkg::CL_NAME_END;
					state_d.phase = ard_pkg::PH_TAG;
				end else begin
					cls = ard_pkg::CL_NAME_BYTE;
				end
			end
			ard_pkg::PH_DATA: begin
				cls          = ard_pkg::CL_DATA;
				state_d.skip = skip_dec;
				rem          = skip_dec;
				if (skip_dec == '0) begin
					state_d.phase = ard_pkg::PH_TAG;
				end
			end
			default: begin
				cls = ard_pkg::CL_IGNORED;
			end
		endcase

		result.byte_class      = cls;
		result.byte_value      = b;
		result.chunk_remaining = rem;
	end

endmodule

`default_nettype wire

// ===== src/archive_record_deframer.sv =====
// Top level of the archive record deframer: parser state, output register and skid stage.
// Depends on ard_pkg and ard_classify.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in channel  (in_valid/in_ready/in_data): one archive byte per beat, plus a
//     restart flag that starts parsing over at the signature with this byte.
//   out channel (out_valid/out_ready/out_data): exactly one result beat per
//     input beat, in order: byte class, the byte itself, and the data bytes
//     still owed in the current chunk.
//   Output: a result is registered into the output register, via the skid stage on a stall.
//   Throughput: one byte per clock while in_ready is high; the parser state updates
//     in the same cycle the byte is accepted, so the only loop is the state update.
//   Stall: when the receiver holds out_ready low, the next result lands in a
//     one-entry skid stage; in_ready drops only while that skid is occupied,
//     so at most two results wait and none are lost or repeated.
//   Reset: arst_n clears the parser to the signature phase with index and
//     chunk count at zero, and empties the output and skid stages.
//   Bytes after the end tag or a signature error are classed ignored until
//   a beat carrying restart arrives.
module archive_record_deframer (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              in_valid,
	output logic                  in_ready,
	input  var ard_pkg::in_beat_t in_data,
	output logic                  out_valid,
	input  var logic              out_ready,
	output ard_pkg::out_beat_t    out_data
);

	ard_pkg::parse_state_t state_q;
	ard_pkg::parse_state_t state_d;
	ard_pkg::out_beat_t    result;
	ard_pkg::out_beat_t    out_q;
	ard_pkg::out_beat_t    skid_q;
	logic                  out_v_q;
	logic                  skid_v_q;
	logic                  accept;

	assign in_ready  = !skid_v_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	ard_classify u_classify (
		.state_q (state_q),
		.beat    (in_data),
		.state_d (state_d),
		.result  (result)
	);

	// parser state advances only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= ard_pkg::PH_SIG;
			state_q.sig_idx <= '0;
			state_q.skip    <= '0;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	// skid holds a result only behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid occupied with output register empty");

	// data phase always owes at least one byte
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == ard_pkg::PH_DATA) |-> (state_q.skip != '0))
		else $error("data phase with zero chunk count");

	// signature index never reaches the signature length
	a_sig_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sig_idx != 3'(ard_pkg::SIG_LEN))
		else $error("signature index out of range");

	// an accepted beat with restart is always a signature beat
	a_restart_sig: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.restart) |->
			(result.byte_class == ard_pkg::CL_SIG_OK ||
			 result.byte_class == ard_pkg::CL_SIG_ERR))
		else $error("restart beat not classed as signature");

endmodule

`default_nettype wire
